[sv/tcw_pkg.sv]
package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;

  localparam logic [7:0]  CH_LF      = 8'd10;
  localparam logic [7:0]  CH_CR      = 8'd13;
  localparam logic [15:0] BLANK_CELL = {8'h07, 8'h20};

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SETCUR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [7:0]       char_code;
    logic [7:0]       attribute;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_x;
    logic [ROW_W-1:0] cursor_y;
    logic             scrolled;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // The screen is kept as a ring of rows: logical row r lives in physical
  // row (r + top) mod ROWS, so a scroll only moves top and blanks one row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    prow = sum[ROW_W-1:0];
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[sv/text_console_writer_core.sv]
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    tcw_pkg::in_item_t  (command)
// out       output     out_valid_o / out_ready_i  tcw_pkg::out_item_t (cursor, cell)
//
// A command is accepted in IDLE and executed in EXEC; a cell read also passes RESP,
// since the memory returns its data in the cycle after the address. A scrolling put
// adds a sweep (blank one row of the ring of rows, then respond); a clear adds one
// over the whole screen, then a response. After reset the controller blanks the memory,
// one cell a cycle, and accepts no word until then. One command is in flight at a time;
// a result stalled in the output register holds back only the delivery of the next one.
module text_console_writer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcw_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcw_pkg::out_item_t  out_item_o
);

  tcw_pkg::mem_req_t  mem_req;
  logic [15:0]        mem_rdata;
  logic               res_valid;
  tcw_pkg::out_item_t res;
  logic               slot_free;

  logic               out_valid_q;
  tcw_pkg::out_item_t out_item_q;

  // The output register can take a new result when it is empty or is being
  // emptied in this very cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rdata_i     (mem_rdata)
  );

  // Character in the low byte, attribute in the high byte of each cell.
  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // Only one command is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command accepted while another is in flight");

  // A result is never produced into a full, stalled output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> slot_free)
    else $error("result would overwrite a pending output");

  // The cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.cursor_x < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                    (out_item_o.cursor_y < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
    else $error("cursor off screen");

  // A scroll leaves the cursor on the last row and reads no cell.
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.scrolled |->
      (out_item_o.cursor_y == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) &&
      (out_item_o.cell_char == 8'd0) && (out_item_o.cell_attr == 8'd0))
    else $error("scrolled result inconsistent");

  // No memory write is issued in the cycle of a memory read.
  a_mem_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> !mem_req.we)
    else $error("read and write issued together");
`endif

endmodule

[sv/tcw_screen_ram.sv]
module tcw_screen_ram (
  input  logic                       clk_i,
  input  tcw_pkg::mem_req_t          req_i,
  output logic [15:0]                rdata_o
);

  logic [15:0] mem [tcw_pkg::CELLS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

[sv/tcw_ctrl.sv]
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  tcw_pkg::in_item_t   in_item_i,
  output logic                in_ready_o,
  input  logic                slot_free_i,
  output logic                res_valid_o,
  output tcw_pkg::out_item_t  res_o,
  output tcw_pkg::mem_req_t   mem_req_o,
  input  logic [15:0]         rdata_i
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]                      state_q, state_d;
  tcw_pkg::in_item_t               item_q;
  logic [tcw_pkg::COL_W-1:0]       cur_x_q, cur_x_d;
  logic [tcw_pkg::ROW_W-1:0]       cur_y_q, cur_y_d;
  logic [tcw_pkg::ROW_W-1:0]       top_q, top_d;
  logic                            scroll_q, scroll_d;
  logic [tcw_pkg::ADDR_W-1:0]      swp_addr_q, swp_addr_d;
  logic [tcw_pkg::CNT_W-1:0]       swp_left_q, swp_left_d;

  logic                            is_lf, is_cr, is_print;
  logic [tcw_pkg::COL_W:0]         put_x_w;
  logic [tcw_pkg::ROW_W:0]         put_y_w;
  logic                            put_scroll;
  logic [tcw_pkg::COL_W-1:0]       put_x, set_x;
  logic [tcw_pkg::ROW_W-1:0]       put_y, set_y;
  logic                            rd_ok;
  logic                            done;

  assign is_lf    = (item_q.char_code == tcw_pkg::CH_LF);
  assign is_cr    = (item_q.char_code == tcw_pkg::CH_CR);
  assign is_print = !is_lf && !is_cr;
  assign rd_ok    = (item_q.col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                    (item_q.row < tcw_pkg::ROW_W'(tcw_pkg::ROWS));
  assign set_x    = (item_q.col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) ?
                    item_q.col : tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  assign set_y    = (item_q.row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) ?
                    item_q.row : tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

  // Cursor movement of a put, with wrap at the right edge.
  always_comb begin
    put_y_w = {1'b0, cur_y_q} + {{tcw_pkg::ROW_W{1'b0}}, is_lf};
    if (is_cr) begin
      put_x_w = '0;
    end else if (is_lf) begin
      put_x_w = {1'b0, cur_x_q};
    end else begin
      put_x_w = {1'b0, cur_x_q} + (tcw_pkg::COL_W+1)'(1);
    end
    if (put_x_w >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
      put_x_w = '0;
      put_y_w = put_y_w + (tcw_pkg::ROW_W+1)'(1);
    end
    put_scroll = (put_y_w >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
    put_x      = put_x_w[tcw_pkg::COL_W-1:0];
    put_y      = put_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) :
                              put_y_w[tcw_pkg::ROW_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    top_d       = top_q;
    scroll_d    = scroll_q;
    swp_addr_d  = swp_addr_q;
    swp_left_d  = swp_left_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    done        = 1'b0;
    in_ready_o  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_INIT, ST_SWEEP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = swp_addr_q;
        mem_req_o.wdata = tcw_pkg::BLANK_CELL;
        swp_addr_d      = swp_addr_q + tcw_pkg::ADDR_W'(1);
        swp_left_d      = swp_left_q - tcw_pkg::CNT_W'(1);
        if (swp_left_q == tcw_pkg::CNT_W'(1)) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scroll_d = 1'b0;
        unique case (item_q.cmd)
          tcw_pkg::CMD_PUT: begin
            if (is_print) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = tcw_pkg::cell_addr(cur_y_q, cur_x_q, top_q);
              mem_req_o.wdata = {item_q.attribute, item_q.char_code};
            end
            cur_x_d = put_x;
            cur_y_d = put_y;
            if (put_scroll) begin
              // The old top row becomes the new bottom row and is blanked.
              scroll_d   = 1'b1;
              swp_addr_d = tcw_pkg::cell_addr('0, '0, top_q);
              swp_left_d = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
              top_d      = (top_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ?
                           '0 : top_q + tcw_pkg::ROW_W'(1);
              state_d    = ST_SWEEP;
            end else begin
              done = 1'b1;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cur_x_d    = '0;
            cur_y_d    = '0;
            top_d      = '0;
            swp_addr_d = '0;
            swp_left_d = tcw_pkg::CNT_W'(tcw_pkg::CELLS);
            state_d    = ST_SWEEP;
          end
          tcw_pkg::CMD_READ: begin
            mem_req_o.re    = rd_ok;
            mem_req_o.raddr = tcw_pkg::cell_addr(item_q.row, item_q.col, top_q);
            state_d         = ST_RESP;
          end
          tcw_pkg::CMD_SETCUR: begin
            cur_x_d = set_x;
            cur_y_d = set_y;
            done    = 1'b1;
          end
        endcase
        if (done) begin
          if (slot_free_i) begin
            res_valid_o = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o          = '0;
    res_o.cursor_x = cur_x_d;
    res_o.cursor_y = cur_y_d;
    res_o.scrolled = scroll_d;
    if ((state_q == ST_RESP) && (item_q.cmd == tcw_pkg::CMD_READ) && rd_ok) begin
      res_o.cell_char = rdata_i[7:0];
      res_o.cell_attr = rdata_i[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      top_q      <= '0;
      scroll_q   <= 1'b0;
      swp_addr_q <= '0;
      swp_left_q <= tcw_pkg::CNT_W'(tcw_pkg::CELLS);
    end else begin
      state_q    <= state_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      top_q      <= top_d;
      scroll_q   <= scroll_d;
      swp_addr_q <= swp_addr_d;
      swp_left_q <= swp_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule
